@@ rtl/poc_pkg.sv @@
`timescale 1ns / 1ps

package poc_pkg;

	// sensor array shape
	localparam int NUM_SENSORS = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int COUNT_BITS  = 16;

	// fixed field widths of the stream words
	localparam int OPCODE_W = 3;
	localparam int INDEX_W  = 8;
	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 2;

	// slave word layout, lowest bit up
	localparam int VAL_POS    = INDEX_W;
	localparam int SINGLE_POS = INDEX_W + 4 * FIELD_W;
	localparam int COUNT_POS  = INDEX_W + 5 * FIELD_W;
	localparam int S_TDATA_W  = INDEX_W + 6 * FIELD_W;
	localparam int S_TUSER_W  = OPCODE_W;
	localparam int M_TDATA_W  = 4 * FIELD_W;
	localparam int M_TUSER_W  = 1 + STATUS_W;

	// shared divider sizing
	localparam int SEL_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
	localparam int DIV_W  = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS;
	localparam int QUO_W  = SAMPLE_BITS;
	localparam int DVD_W  = QUO_W + DIV_W;
	localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
	localparam int STEP_W = $clog2(QUO_W);

	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_SAMPLE  = OPCODE_W'(0);
	localparam logic [OPCODE_W-1:0] OP_GET     = OPCODE_W'(1);
	localparam logic [OPCODE_W-1:0] OP_SET_ONE = OPCODE_W'(2);
	localparam logic [OPCODE_W-1:0] OP_SET_ALL = OPCODE_W'(3);
	localparam logic [OPCODE_W-1:0] OP_START   = OPCODE_W'(4);

	// result status and kind
	localparam logic [STATUS_W-1:0] STAT_OK   = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] STAT_FAIL = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] STAT_BUSY = STATUS_W'(2);
	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_EMIT_FRAME,
		ST_EMIT_REPORT
	} state_t;

	typedef enum logic {
		MODE_FRAME,
		MODE_AVG
	} mode_t;

endpackage

@@ rtl/proximity_offset_calibrator.sv @@
`timescale 1ns / 1ps

// proximity offset calibrator: each slave word is a frame of four readings
// (opcode 0) or a calibration command (get, set one, set all, start auto
// calibration over n frames). a frame comes back with every reading corrected
// as floor((v - o) * full_scale / (full_scale - o)), 0 when v <= o; while an
// auto calibration runs the raw readings are summed and, on the n-th frame,
// the corrected frame (old offsets, tlast low) is followed by an offsets
// report with the new averages. commands during calibration get status busy.
// all divisions go through one restoring divider that retires one quotient bit
// per cycle. a frame is accepted, then each sensor gets a setup step and,
// when its reading is above its offset, a divide of SAMPLE_BITS (16) quotient
// bits, and the frame is emitted. the frame that ends a calibration is followed
// by a setup step and a divide per sensor for the averages. commands that
// answer emit a report; a start while idle and a reserved opcode do not.
// slave tready is high only while the block is idle; the result sits in an
// output register, so a stalled master side holds the block in its emit state
module proximity_offset_calibrator (
	input  logic                                clk,
	input  logic                                arst_n,
	// slave side
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// sensor_index[7:0], value_0..value_3[71:8], single_offset[87:72],
	// measurement_count[103:88]
	input  logic [poc_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	// opcode[2:0]
	input  logic [poc_pkg::S_TUSER_W-1:0]       s_axis_tuser,
	// master side
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// data_0[15:0], data_1[31:16], data_2[47:32], data_3[63:48]
	output logic [poc_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	// kind[0], status[2:1]
	output logic [poc_pkg::M_TUSER_W-1:0]       m_axis_tuser,
	// last_result
	output logic                                m_axis_tlast
);

	import poc_pkg::*;

	// sequencer
	state_t state_q, state_d;
	mode_t  mode_q;
	logic [SEL_W-1:0]    sel_q;
	logic [STEP_W-1:0]   step_q;
	logic [STATUS_W-1:0] status_q;
	logic                cal_done_q;

	// calibration state
	logic [SAMPLE_BITS-1:0] offsets_q [NUM_SENSORS];
	logic [SUM_W-1:0]       sums_q    [NUM_SENSORS];
	logic [COUNT_BITS-1:0]  target_q;
	logic [COUNT_BITS-1:0]  frames_q;

	// frame payload and results
	logic [SAMPLE_BITS-1:0] vals_q [NUM_SENSORS];
	logic [SAMPLE_BITS-1:0] res_q  [NUM_SENSORS];

	// shared divider
	logic [DIV_W-1:0] rem_q;
	logic [QUO_W-1:0] lo_q;
	logic [DIV_W-1:0] divisor_q;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic [M_TUSER_W-1:0] m_tuser_q;
	logic                 m_tlast_q;

	// input word decode
	logic [OPCODE_W-1:0]    in_op;
	logic [INDEX_W-1:0]     in_index;
	logic [SAMPLE_BITS-1:0] in_val [NUM_SENSORS];
	logic [SAMPLE_BITS-1:0] in_single;
	logic [COUNT_BITS-1:0]  in_count;

	logic accept;
	logic busy;
	logic bad_index;
	logic out_free;
	logic load_frame;
	logic load_report;
	logic [COUNT_BITS-1:0] frames_inc;
	logic last_sel;
	logic div_last;

	// setup path
	logic [SAMPLE_BITS-1:0]   cur_v;
	logic [SAMPLE_BITS-1:0]   cur_o;
	logic                     skip;
	logic [SAMPLE_BITS-1:0]   diff;
	logic [2*SAMPLE_BITS-1:0] numer_frame;
	logic [DVD_W-1:0]         dividend;
	logic [DIV_W-1:0]         dvs;

	// divide step
	logic [DIV_W:0]   trial;
	logic             fits;
	logic [DIV_W-1:0] rem_next;
	logic [QUO_W-1:0] lo_next;

	logic [M_TDATA_W-1:0] frame_data;
	logic [M_TDATA_W-1:0] report_data;

	always_comb begin
		in_op     = s_axis_tuser[OPCODE_W-1:0];
		in_index  = s_axis_tdata[INDEX_W-1:0];
		in_single = s_axis_tdata[SINGLE_POS +: SAMPLE_BITS];
		in_count  = s_axis_tdata[COUNT_POS +: COUNT_BITS];
		for (int i = 0; i < NUM_SENSORS; i++) begin
			in_val[i] = s_axis_tdata[VAL_POS + FIELD_W * i +: SAMPLE_BITS];
		end
	end

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign busy       = target_q != '0;
	assign bad_index  = in_index >= INDEX_W'(NUM_SENSORS);
	assign out_free   = !m_tvalid_q || m_axis_tready;
	assign frames_inc = COUNT_BITS'(frames_q + 1'b1);
	assign last_sel   = sel_q == SEL_W'(NUM_SENSORS - 1);
	assign div_last   = step_q == STEP_W'(QUO_W - 1);

	// operands for the selected sensor: scaled difference over the headroom,
	// or the running sum over the frame count
	always_comb begin
		cur_v       = vals_q[sel_q];
		cur_o       = offsets_q[sel_q];
		skip        = (mode_q == MODE_FRAME) && (cur_v <= cur_o);
		diff        = cur_v - cur_o;
		// diff * full_scale as a shift and subtract
		numer_frame = {diff, {SAMPLE_BITS{1'b0}}} - (2*SAMPLE_BITS)'(diff);
		if (mode_q == MODE_FRAME) begin
			dividend = DVD_W'(numer_frame);
			dvs      = DIV_W'(FULL_SCALE - cur_o);
		end else begin
			dividend = DVD_W'(sums_q[sel_q]);
			dvs      = DIV_W'(target_q);
		end
	end

	// one restoring step; the high half of the dividend is always below the
	// divisor, so the quotient fits QUO_W bits
	always_comb begin
		trial    = {rem_q, lo_q[QUO_W-1]};
		fits     = trial >= {1'b0, divisor_q};
		rem_next = fits ? DIV_W'(trial - {1'b0, divisor_q}) : DIV_W'(trial);
		lo_next  = {lo_q[QUO_W-2:0], fits};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_SAMPLE:                     state_d = ST_SETUP;
						OP_GET, OP_SET_ONE, OP_SET_ALL: state_d = ST_EMIT_REPORT;
						OP_START:                      state_d = busy ? ST_EMIT_REPORT : ST_IDLE;
						default:                       state_d = ST_IDLE;
					endcase
				end
			end
			ST_SETUP: begin
				if (!skip) begin
					state_d = ST_DIV;
				end else if (last_sel) begin
					state_d = ST_EMIT_FRAME;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					if (!last_sel) begin
						state_d = ST_SETUP;
					end else if (mode_q == MODE_FRAME) begin
						state_d = ST_EMIT_FRAME;
					end else begin
						state_d = ST_EMIT_REPORT;
					end
				end
			end
			ST_EMIT_FRAME: begin
				if (out_free) begin
					state_d = cal_done_q ? ST_SETUP : ST_IDLE;
				end
			end
			ST_EMIT_REPORT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		load_frame    = 1'b0;
		load_report   = 1'b0;
		case (state_q)
			ST_IDLE:        s_axis_tready = 1'b1;
			ST_EMIT_FRAME:  load_frame    = out_free;
			ST_EMIT_REPORT: load_report   = out_free;
			default: begin
			end
		endcase
	end

	// control and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_FRAME;
			sel_q      <= '0;
			step_q     <= '0;
			status_q   <= STAT_OK;
			cal_done_q <= 1'b0;
			target_q   <= '0;
			frames_q   <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				offsets_q[i] <= '0;
				sums_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// busy wins over a bad index
						status_q <= busy ? STAT_BUSY :
							((in_op == OP_SET_ONE && bad_index) ? STAT_FAIL : STAT_OK);
						case (in_op)
							OP_SAMPLE: begin
								mode_q     <= MODE_FRAME;
								sel_q      <= '0;
								cal_done_q <= busy && (frames_inc == target_q);
								if (busy) begin
									frames_q <= (frames_inc == target_q) ? '0 : frames_inc;
									for (int i = 0; i < NUM_SENSORS; i++) begin
										sums_q[i] <= sums_q[i] + SUM_W'(in_val[i]);
									end
								end
							end
							OP_SET_ONE: begin
								if (!busy && !bad_index) begin
									offsets_q[in_index[SEL_W-1:0]] <= in_single;
								end
							end
							OP_SET_ALL: begin
								if (!busy) begin
									for (int i = 0; i < NUM_SENSORS; i++) begin
										offsets_q[i] <= in_val[i];
									end
								end
							end
							OP_START: begin
								if (!busy && in_count != '0) begin
									target_q <= in_count;
									frames_q <= '0;
									for (int i = 0; i < NUM_SENSORS; i++) begin
										sums_q[i] <= '0;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SETUP: begin
					step_q <= '0;
					if (skip && !last_sel) begin
						sel_q <= SEL_W'(sel_q + 1'b1);
					end
				end
				ST_DIV: begin
					step_q <= STEP_W'(step_q + 1'b1);
					if (div_last) begin
						if (mode_q == MODE_AVG) begin
							offsets_q[sel_q] <= lo_next[SAMPLE_BITS-1:0];
						end
						if (!last_sel) begin
							sel_q <= SEL_W'(sel_q + 1'b1);
						end else if (mode_q == MODE_AVG) begin
							// averages stored, calibration over
							target_q <= '0;
							status_q <= STAT_OK;
						end
					end
				end
				ST_EMIT_FRAME: begin
					if (out_free && cal_done_q) begin
						mode_q     <= MODE_AVG;
						sel_q      <= '0;
						cal_done_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase

			if (load_frame || load_report) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result words
	always_comb begin
		frame_data  = '0;
		report_data = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			frame_data[FIELD_W * i +: FIELD_W]  = FIELD_W'(res_q[i]);
			report_data[FIELD_W * i +: FIELD_W] = FIELD_W'(offsets_q[i]);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_SENSORS; i++) begin
				vals_q[i] <= in_val[i];
			end
		end
		if (state_q == ST_SETUP) begin
			if (skip) begin
				res_q[sel_q] <= '0;
			end else begin
				rem_q     <= dividend[DVD_W-1 -: DIV_W];
				lo_q      <= dividend[QUO_W-1:0];
				divisor_q <= dvs;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q <= rem_next;
			lo_q  <= lo_next;
			if (div_last && mode_q == MODE_FRAME) begin
				res_q[sel_q] <= lo_next[SAMPLE_BITS-1:0];
			end
		end
		if (load_frame) begin
			m_tdata_q <= frame_data;
			m_tuser_q <= {STAT_OK, KIND_FRAME};
			m_tlast_q <= !cal_done_q;
		end else if (load_report) begin
			m_tdata_q <= report_data;
			m_tuser_q <= {status_q, KIND_REPORT};
			m_tlast_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;
	assign m_axis_tlast  = m_tlast_q;

	// frame counter is clear whenever no calibration runs
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		target_q == '0 |-> frames_q == '0)
		else $error("frame count set without calibration");

	// between words a running calibration has frames left to go
	a_count_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && target_q != '0) |-> frames_q < target_q)
		else $error("frame count reached target without finishing");

	// restoring divider keeps its partial remainder below the divisor
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < divisor_q)
		else $error("divider remainder out of range");

	// busy reports only come out while a calibration runs
	a_busy_report: assert property (@(posedge clk) disable iff (!arst_n)
		(load_report && status_q == STAT_BUSY) |-> target_q != '0)
		else $error("busy status without calibration");

endmodule

@@ tb/proximity_offset_calibrator_tb.sv @@
`timescale 1ns / 1ps

module proximity_offset_calibrator_tb;
	import poc_pkg::*;

	// reserved opcodes, the block drops these without a word out
	localparam logic [OPCODE_W-1:0] OP_RSVD_FIRST = OPCODE_W'(5);
	localparam logic [OPCODE_W-1:0] OP_RSVD_LAST  = OPCODE_W'(7);

	localparam int NUM_RANDOM  = 400;
	localparam int QUIET_LIMIT = 5000;

	// one command or frame on the slave side
	typedef struct packed {
		logic [OPCODE_W-1:0]         opcode;
		logic [INDEX_W-1:0]          index;
		logic [3:0][FIELD_W-1:0]     val;
		logic [FIELD_W-1:0]          single;
		logic [FIELD_W-1:0]          count;
	} sensor_cmd_t;

	// one word on the master side
	typedef struct packed {
		logic                        kind;
		logic [STATUS_W-1:0]         status;
		logic [3:0][FIELD_W-1:0]     data;
		logic                        last;
	} report_word_t;

	typedef struct packed {
		sensor_cmd_t                 cmd;
		bit                          typed;
		report_word_t                want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// sensor_index, value_0..value_3, single_offset, measurement_count
	logic [S_TDATA_W-1:0]   s_axis_tdata;
	// opcode
	logic [S_TUSER_W-1:0]   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// data_0..data_3
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	// kind, status
	logic [M_TUSER_W-1:0]   m_axis_tuser;
	logic                   m_axis_tlast;

	// shadow of the block state
	logic [3:0][FIELD_W-1:0] offs;
	logic [31:0]             acc_sums [4];
	logic [FIELD_W-1:0]      avg_target;
	logic [FIELD_W-1:0]      avg_seen;

	report_word_t            pending_results [$];
	dir_row_t                dir_rows [$];
	int                      mismatch_count;
	int                      quiet_cycles;
	int                      ready_span;
	int                      ready_pick;

	proximity_offset_calibrator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// offset removal stretched back to full scale, floor division
	function automatic logic [FIELD_W-1:0] rescale(logic [FIELD_W-1:0] v,
			logic [FIELD_W-1:0] o);
		if (v <= o)
			return '0;
		return FIELD_W'((64'(v - o) * 64'(FULL_SCALE)) / 64'(FULL_SCALE - o));
	endfunction

	// advance the shadow state by one accepted word and queue what comes out
	task automatic calibrate_predict(input sensor_cmd_t c, input bit keep);
		report_word_t r;
		bit           busy;
		bit           emit;
		busy = (avg_target != 0);
		emit = 1'b1;
		r.kind = KIND_REPORT;
		r.status = STAT_OK;
		r.data = '0;
		r.last = 1'b1;
		if (c.opcode == OP_SAMPLE) begin
			r.kind = KIND_FRAME;
			for (int i = 0; i < NUM_SENSORS; i++) begin
				if (busy)
					acc_sums[i] += 32'(c.val[i]);
				r.data[i] = rescale(c.val[i], offs[i]);
			end
			if (busy) begin
				avg_seen++;
				// last frame of the run: frame first, then the new averages
				if (avg_seen == avg_target) begin
					r.last = 1'b0;
					if (keep)
						pending_results.push_back(r);
					for (int i = 0; i < NUM_SENSORS; i++)
						offs[i] = FIELD_W'(acc_sums[i] / 32'(avg_target));
					avg_target = '0;
					avg_seen = '0;
					r.kind = KIND_REPORT;
					r.data = offs;
					r.last = 1'b1;
				end
			end
		end else if (c.opcode > OP_START) begin
			emit = 1'b0;
		end else begin
			if (busy) begin
				r.status = STAT_BUSY;
			end else begin
				case (c.opcode)
					OP_SET_ONE: begin
						if (c.index < NUM_SENSORS)
							offs[c.index[SEL_W-1:0]] = c.single;
						else
							r.status = STAT_FAIL;
					end
					OP_SET_ALL: offs = c.val;
					OP_START: begin
						emit = 1'b0;
						if (c.count != 0) begin
							avg_target = c.count;
							avg_seen = '0;
							for (int i = 0; i < 4; i++)
								acc_sums[i] = '0;
						end
					end
					default: ;
				endcase
			end
			r.data = offs;
		end
		if (emit && keep)
			pending_results.push_back(r);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	task automatic push_cmd(input sensor_cmd_t c, input bit typed, input report_word_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {c.count, c.single, c.val, c.index};
		s_axis_tuser <= c.opcode;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		// typed rows still move the shadow state, but their word is fixed
		calibrate_predict(c, !typed);
		if (typed)
			pending_results.push_back(want);
	endtask

	task automatic await_drain();
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic dir_row_t mk(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
			logic [63:0] v, logic [FIELD_W-1:0] one, logic [FIELD_W-1:0] cnt, bit typed,
			logic kind, logic [STATUS_W-1:0] st, logic [63:0] d);
		dir_row_t r;
		r.cmd.opcode = op;
		r.cmd.index = idx;
		r.cmd.val = v;
		r.cmd.single = one;
		r.cmd.count = cnt;
		r.typed = typed;
		r.want.kind = kind;
		r.want.status = st;
		r.want.data = d;
		r.want.last = 1'b1;
		return r;
	endfunction

	// random traffic, leaning on readings close to the current offsets
	function automatic sensor_cmd_t random_cmd();
		sensor_cmd_t c;
		int          p;
		p = $urandom_range(0, 99);
		c.index = ($urandom_range(0, 9) == 0) ? INDEX_W'($urandom_range(0, 255))
			: INDEX_W'($urandom_range(0, NUM_SENSORS - 1));
		for (int i = 0; i < 4; i++) begin
			case ($urandom_range(0, 9))
				0: c.val[i] = '0;
				1: c.val[i] = '1;
				2, 3: c.val[i] = FIELD_W'(offs[i] + $urandom_range(0, 4) - 2);
				default: c.val[i] = FIELD_W'($urandom);
			endcase
		end
		c.single = ($urandom_range(0, 4) == 0) ? '1 : FIELD_W'($urandom);
		c.count = ($urandom_range(0, 9) == 0) ? FIELD_W'($urandom_range(0, 15))
			: FIELD_W'($urandom_range(1, 6));
		if (p < 50)
			c.opcode = OP_SAMPLE;
		else if (p < 58)
			c.opcode = OP_GET;
		else if (p < 68)
			c.opcode = OP_SET_ONE;
		else if (p < 76)
			c.opcode = OP_SET_ALL;
		else if (p < 94)
			c.opcode = OP_START;
		else
			c.opcode = OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
		return c;
	endfunction

	// sink side: ready runs of random length, short stalls, now and then a long one
	always @(posedge clk) begin
		if (ready_span == 0) begin
			ready_pick = $urandom_range(0, 99);
			if (ready_pick < 55) begin
				m_axis_tready <= 1'b1;
				ready_span <= $urandom_range(1, 30);
			end else if (ready_pick < 95) begin
				m_axis_tready <= 1'b0;
				ready_span <= $urandom_range(1, 3);
			end else begin
				m_axis_tready <= 1'b0;
				ready_span <= $urandom_range(20, 80);
			end
		end else begin
			ready_span <= ready_span - 1;
		end
	end

	// result checker: every word against the oldest expectation
	always @(posedge clk) begin
		report_word_t exp_w;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected word: tuser %h tdata %h tlast %b",
					m_axis_tuser, m_axis_tdata, m_axis_tlast);
				mismatch_count++;
			end else begin
				exp_w = pending_results.pop_front();
				if (m_axis_tuser[0] !== exp_w.kind) begin
					$error("kind: expected %h, got %h", exp_w.kind, m_axis_tuser[0]);
					mismatch_count++;
				end
				if (m_axis_tuser[2:1] !== exp_w.status) begin
					$error("status: expected %h, got %h", exp_w.status, m_axis_tuser[2:1]);
					mismatch_count++;
				end
				for (int i = 0; i < 4; i++) begin
					if (m_axis_tdata[FIELD_W*i +: FIELD_W] !== exp_w.data[i]) begin
						$error("data_%0d: expected %h, got %h", i, exp_w.data[i],
							m_axis_tdata[FIELD_W*i +: FIELD_W]);
						mismatch_count++;
					end
				end
				if (m_axis_tlast !== exp_w.last) begin
					$error("last_result: expected %b, got %b", exp_w.last, m_axis_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// cycles since the last handshake on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin
		report_word_t none;
		dir_row_t     tail_row;
		none = '0;
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		m_axis_tready <= 1'b0;
		ready_span = 0;
		quiet_cycles = 0;
		mismatch_count = 0;
		offs = '0;
		for (int i = 0; i < 4; i++)
			acc_sums[i] = '0;
		avg_target = '0;
		avg_seen = '0;

		// directed rows: reset state, extremes, error codes, calibration corners
		dir_rows.push_back(mk(OP_GET, 8'h00, 64'h0, 16'h0, 16'h0,
			1, KIND_REPORT, STAT_OK, 64'h0));
		// zero offsets pass readings straight through
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'h8000_0001_FFFF_0000, 16'h0, 16'h0,
			1, KIND_FRAME, STAT_OK, 64'h8000_0001_FFFF_0000));
		// bad sensor index
		dir_rows.push_back(mk(OP_SET_ONE, 8'h04, 64'h0, 16'h1234, 16'h0,
			1, KIND_REPORT, STAT_FAIL, 64'h0));
		dir_rows.push_back(mk(OP_SET_ONE, 8'hFF, 64'h0, 16'hFFFF, 16'hFFFF,
			1, KIND_REPORT, STAT_FAIL, 64'h0));
		// offset at full scale zeroes every reading of that sensor
		dir_rows.push_back(mk(OP_SET_ONE, 8'h00, 64'h0, 16'hFFFF, 16'h0,
			1, KIND_REPORT, STAT_OK, 64'h0000_0000_0000_FFFF));
		dir_rows.push_back(mk(OP_SAMPLE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0,
			1, KIND_FRAME, STAT_OK, 64'hFFFF_FFFF_FFFF_0000));
		dir_rows.push_back(mk(OP_SET_ONE, 8'h03, 64'hFFFF_FFFF_FFFF_FFFF, 16'h8000, 16'h0,
			1, KIND_REPORT, STAT_OK, 64'h8000_0000_0000_FFFF));
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFF_7FFF_0001_FFFF, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_SET_ALL, 8'h00, 64'hFFFE_7FFF_0001_0000, 16'h0, 16'h0,
			1, KIND_REPORT, STAT_OK, 64'hFFFE_7FFF_0001_0000));
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFF_8000_0002_0000, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));
		// readings equal to their offsets
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFE_7FFF_0001_0000, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));
		// reserved opcodes and a zero count: nothing comes out
		dir_rows.push_back(mk(OP_RSVD_FIRST, 8'h01, 64'h1234_5678_9ABC_DEF0, 16'h5555,
			16'h0003, 0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_RSVD_FIRST + 3'd1, 8'h02, 64'h0, 16'hAAAA, 16'h0001,
			0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_RSVD_LAST, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF,
			16'hFFFF, 0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_START, 8'h00, 64'h0, 16'h0, 16'h0000,
			0, KIND_FRAME, STAT_OK, 64'h0));
		// two-frame calibration, commands in between answer busy
		dir_rows.push_back(mk(OP_START, 8'h00, 64'h0, 16'h0, 16'h0002,
			0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_GET, 8'h00, 64'h0, 16'h0, 16'h0,
			1, KIND_REPORT, STAT_BUSY, 64'hFFFE_7FFF_0001_0000));
		dir_rows.push_back(mk(OP_SET_ALL, 8'h00, 64'h1111_2222_3333_4444, 16'h0, 16'h0,
			1, KIND_REPORT, STAT_BUSY, 64'hFFFE_7FFF_0001_0000));
		dir_rows.push_back(mk(OP_START, 8'h00, 64'h0, 16'h0, 16'h0005,
			1, KIND_REPORT, STAT_BUSY, 64'hFFFE_7FFF_0001_0000));
		// busy wins over a bad index
		dir_rows.push_back(mk(OP_SET_ONE, 8'h09, 64'h0, 16'h0042, 16'h0,
			1, KIND_REPORT, STAT_BUSY, 64'hFFFE_7FFF_0001_0000));
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFF_8001_0003_1000, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFE_7FFE_0000_2001, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));
		// single-frame calibration at full scale, then everything reads 0
		dir_rows.push_back(mk(OP_START, 8'h00, 64'h0, 16'h0, 16'h0001,
			0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));
		dir_rows.push_back(mk(OP_SAMPLE, 8'h00, 64'hFFFF_0000_8000_FFFE, 16'h0, 16'h0,
			0, KIND_FRAME, STAT_OK, 64'h0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			push_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].want);

		for (int n = 0; n < NUM_RANDOM; n++) begin
			// hold the sender off until the sink has caught up
			if (n == 0 || n == NUM_RANDOM / 2) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				await_drain();
			end
			push_cmd(random_cmd(), 0, none);
		end

		// finish any open calibration, then start the longest one and poke at it
		while (avg_target != 0)
			push_cmd(random_cmd() | '0, 0, none);
		tail_row = mk(OP_START, 8'h00, 64'h0, 16'h0, 16'hFFFF, 0, 1'b0, STAT_OK, 64'h0);
		push_cmd(tail_row.cmd, 0, none);
		tail_row = mk(OP_GET, 8'h00, 64'h0, 16'h0, 16'h0, 0, 1'b0, STAT_OK, 64'h0);
		push_cmd(tail_row.cmd, 0, none);
		for (int n = 0; n < 3; n++) begin
			tail_row = mk(OP_SAMPLE, 8'h00, {$urandom, $urandom}, 16'h0, 16'h0,
				0, 1'b0, STAT_OK, 64'h0);
			push_cmd(tail_row.cmd, 0, none);
		end
		s_axis_tvalid <= 1'b0;

		await_drain();
		repeat (200) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
